// ===== src/io_port_decoder_assert.svh =====
// Assertion macros for the I/O port decoder.
// Both sample on clk and are disabled while rst is high.
`ifndef IO_PORT_DECODER_ASSERT_SVH
`define IO_PORT_DECODER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define IPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("io_port_decoder: assertion failed");

// Consequent holds in the cycle after the antecedent
`define IPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("io_port_decoder: assertion failed");

`endif

// ===== src/ipd_pkg.sv =====
`default_nettype none

package ipd_pkg;

  // Table geometry
  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);

  // Request kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Incoming request
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic [7:0]  write_data;
    logic        broadcast;
    logic        dos_flag;
    logic        rom_flag;
    logic        cpm_flag;
    logic [4:0]  entry_slot;
    logic [15:0] entry_mask;
    logic [5:0]  entry_conditions;
    logic [1:0]  entry_handlers;
  } req_t;

  // Outgoing result
  typedef struct packed {
    logic       handler_called;
    logic [4:0] entry_index;
    logic       is_write;
    logic [7:0] bus_data;
    logic       stop_request;
    logic       last;
  } res_t;

  // One table entry as held in the memory (40 bits)
  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] value;
    logic [5:0]  cond;
    logic [1:0]  handlers;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== src/io_port_decoder.sv =====
// I/O port decoder: mask/value table in a synchronous RAM, scanned in order.
// Port access: N entries (1..32) are scanned in order, one entry per cycle through the RAM read
//   port while no held hit waits on a stalled output; ST_FINISH then pushes the final result.
// A new request is taken only in ST_IDLE, once the last access is done; a table load gives no result.
// Reset (rst, synchronous): all entry valid bits and panic_enable cleared, so every
//   entry reads as zero (no handlers, terminal mask); output register emptied.
`default_nettype none

module io_port_decoder (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_data,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire ipd_pkg::req_t req,
  output      logic          res_valid,
  input  wire logic          res_stall,
  output      ipd_pkg::res_t res
);

  import ipd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state, state_next;

  logic panic_enable;

  // table storage and per-entry valid bits
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  entry_t             rd_entry;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_addr;

  // access context
  logic [15:0]      acc_port;
  logic [7:0]       acc_data;
  logic             acc_write;
  logic             acc_bcast;
  logic             acc_dos;
  logic             acc_rom;
  logic             acc_cpm;

  // scan state
  logic [IDX_W-1:0] scan_idx;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_index;
  logic             caught;

  logic   accept;
  logic   load_we;
  entry_t ent;
  logic   addr_hit;
  logic   need_ok;
  logic   hit;
  logic   caught_new;
  logic   scan_end;
  logic   step;
  logic   out_free;
  logic   push_valid;
  res_t   push_item;

  function automatic logic cond_ok(input logic [1:0] c, input logic f);
    cond_ok = c[1] || (c[0] == f);
  endfunction

  assign accept   = req_valid && !req_stall;
  assign out_free = !res_valid || !res_stall;
  assign load_we  = accept && (req.kind == KIND_LOAD) && (32'(req.entry_slot) < ENTRIES);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      panic_enable <= 1'b0;
    end else if (cfg_write) begin
      panic_enable <= cfg_data;
    end
  end

  // table RAM: one write port for loads, registered read for the scan
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[req.entry_slot[IDX_W-1:0]] <= '{mask: req.entry_mask, value: req.port,
                                          cond: req.entry_conditions,
                                          handlers: req.entry_handlers};
    end
    rd_entry <= mem[rd_addr];
  end

  // valid bits; an entry never loaded reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (load_we) begin
        vld[req.entry_slot[IDX_W-1:0]] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // match of the entry under evaluation
  always_comb begin
    ent      = rd_vld ? rd_entry : '0;
    addr_hit = (acc_port & ent.mask) == (ent.value & ent.mask);
    need_ok  = acc_write ? ent.handlers[1] : ent.handlers[0];
    hit      = addr_hit && need_ok && cond_ok(ent.cond[1:0], acc_dos) &&
               cond_ok(ent.cond[3:2], acc_rom) && cond_ok(ent.cond[5:4], acc_cpm);
    if (!hit) begin
      caught_new = caught;
    end else if (acc_write) begin
      caught_new = caught || !acc_bcast;
    end else begin
      caught_new = ent.mask != '0;
    end
    scan_end = caught_new || (ent.mask == '0) || (scan_idx == LAST_IDX);
    // a second hit must hand the held one to the output first
    step     = (state == ST_SCAN) && (!hit || !pend_valid || out_free);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && ((req.kind == KIND_READ) || (req.kind == KIND_WRITE))) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: request stall, RAM address, result push
  always_comb begin
    req_stall  = 1'b1;
    rd_addr    = scan_idx;
    push_valid = 1'b0;
    push_item  = '{handler_called: 1'b1, entry_index: 5'(pend_index),
                   is_write: acc_write, bus_data: acc_data,
                   stop_request: 1'b0, last: 1'b0};
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        rd_addr   = '0;
      end
      ST_SCAN: begin
        if (step && !scan_end) begin
          rd_addr = scan_idx + IDX_W'(1);
        end
        push_valid = step && hit && pend_valid;
      end
      ST_FINISH: begin
        push_valid                = out_free;
        push_item.handler_called  = pend_valid;
        push_item.entry_index     = pend_valid ? 5'(pend_index) : 5'd0;
        push_item.stop_request    = !caught && panic_enable;
        push_item.last            = 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // control and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      caught     <= 1'b0;
      scan_idx   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        scan_idx   <= '0;
        pend_valid <= 1'b0;
        caught     <= 1'b0;
      end else if (step) begin
        caught <= caught_new;
        if (hit) begin
          pend_valid <= 1'b1;
        end
        if (!scan_end) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end
    end
  end

  // access context and held hit
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_port  <= req.port;
      acc_write <= req.kind == KIND_WRITE;
      acc_data  <= (req.kind == KIND_WRITE) ? req.write_data : 8'd0;
      acc_bcast <= req.broadcast;
      acc_dos   <= req.dos_flag;
      acc_rom   <= req.rom_flag;
      acc_cpm   <= req.cpm_flag;
    end
    if (step && hit) begin
      pend_index <= scan_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push_valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      res <= push_item;
    end
  end

  `include "io_port_decoder_assert.svh"

  `IPD_ASSERT_SAME(a_stop_on_last, res_valid && res.stop_request, res.last)
  `IPD_ASSERT_SAME(a_miss_is_last, res_valid && !res.handler_called, res.last)
  `IPD_ASSERT_SAME(a_read_single_hit, (state == ST_SCAN) && !acc_write, !pend_valid)
  `IPD_ASSERT_NEXT(a_finish_done, (state == ST_FINISH) && out_free, state == ST_IDLE)

endmodule

`default_nettype wire
